### sv/assert_macros.svh
// Assertion macros used by the top level of the duty slew limiter.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

### sv/mdsl_pkg.sv
// Package for the multichannel duty slew limiter: sizes, codes and types.
// No dependencies; used by mdsl_slew_unit and multichannel_duty_slew_limiter.
`timescale 1ns / 1ps

package mdsl_pkg;

	// Store geometry
	localparam int CHANNELS  = 5;
	localparam int DUTY_BITS = 12;
	localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Fixed port field widths
	localparam int CFG_BITS      = 12;
	localparam int CHAN_BITS     = 4;
	localparam int REQ_BITS      = 17;
	localparam int RES_DUTY_BITS = 12;
	localparam int CFG_IDX_BITS  = 1;

	// Width wide enough to compare duty values against configuration values
	localparam int MAG_BITS = (DUTY_BITS > CFG_BITS) ? DUTY_BITS : CFG_BITS;
	localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DUTY  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RATE_STEP = 1'd1;

	// Configuration reset values
	localparam logic [CFG_BITS-1:0] MAX_DUTY_RST  = 12'd4095;
	localparam logic [CFG_BITS-1:0] RATE_STEP_RST = 12'd32;

	// Request actions
	typedef enum logic [1:0] {
		ACT_SET  = 2'd0,
		ACT_READ = 2'd1,
		ACT_TICK = 2'd2,
		ACT_STOP = 2'd3
	} action_t;

	// Result kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_DRIVE = 1'b1;

	// Sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	// Operands for the shared slew unit
	typedef struct packed {
		logic                 clear;
		logic [DUTY_BITS-1:0] target;
		logic [DUTY_BITS-1:0] current;
		logic [CFG_BITS-1:0]  step;
	} slew_req_t;

endpackage

### sv/mdsl_slew_unit.sv
// Shared slew step: next current duty of one channel from its target.
// Depends on mdsl_pkg for widths and the slew_req_t operand struct.
`timescale 1ns / 1ps

module mdsl_slew_unit import mdsl_pkg::*; (
	input  slew_req_t            req,
	output logic [DUTY_BITS-1:0] next_duty
);

	logic                up;
	logic [MAG_BITS-1:0] gap;
	logic [MAG_BITS:0]   sum;
	logic [MAG_BITS:0]   dif;

	// Distance between target and current, and both step candidates
	always_comb begin
		up  = req.target > req.current;
		gap = up ? (MAG_BITS'(req.target) - MAG_BITS'(req.current))
		         : (MAG_BITS'(req.current) - MAG_BITS'(req.target));
		sum = (MAG_BITS+1)'(req.current) + (MAG_BITS+1)'(req.step);
		dif = (MAG_BITS+1)'(req.current) - (MAG_BITS+1)'(req.step);
	end

	// Move by one step when far away, snap to target when close, zero on stop
	always_comb begin
		if (req.clear) begin
			next_duty = '0;
		end else if (gap > MAG_BITS'(req.step)) begin
			next_duty = up ? DUTY_BITS'(sum) : DUTY_BITS'(dif);
		end else begin
			next_duty = req.target;
		end
	end

endmodule

### sv/multichannel_duty_slew_limiter.sv
// Top level of the multichannel duty slew limiter: stores, sequencer, output register.
// Depends on mdsl_pkg, mdsl_slew_unit and assert_macros.svh.
//
//   channel  handshake           payload
//   in       in_valid/in_ready   action, channel, duty_request
//   out      out_valid/out_ready result_kind, result_channel, result_duty, last
//   cfg      cfg_we              cfg_index, cfg_data (no wait, no read-back)
//
// A set writes the clamped target when taken; a read loads its reply into the output register.
// After a tick or stop is taken, the shared slew unit handles one channel per cycle
// while the output is not stalled, and each channel's drive update goes through the
// single output register.
// A stall on the output holds the walk on its current channel.
// Reset clears all targets and currents at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multichannel_duty_slew_limiter import mdsl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic [CHAN_BITS-1:0]     channel,
	input  logic signed [REQ_BITS-1:0] duty_request,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     result_kind,
	output logic [CHAN_BITS-1:0]     result_channel,
	output logic [RES_DUTY_BITS-1:0] result_duty,
	output logic                     last,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_BITS-1:0]      cfg_data
);

	state_t               state_q, state_d;
	logic [IDX_BITS-1:0]  walk_idx_q, walk_idx_d;
	logic                 walk_stop_q, walk_stop_d;
	logic [DUTY_BITS-1:0] target_q [CHANNELS];
	logic [DUTY_BITS-1:0] current_q [CHANNELS];
	logic [CFG_BITS-1:0]  max_duty_q;
	logic [CFG_BITS-1:0]  rate_step_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic [CHAN_BITS-1:0] out_chan_q;
	logic [DUTY_BITS-1:0] out_duty_q;
	logic                 out_last_q;

	logic                 in_fire;
	logic                 out_free;
	logic                 chan_ok;
	logic [IDX_BITS-1:0]  chan_idx;
	logic [DUTY_BITS-1:0] limit;
	logic [DUTY_BITS-1:0] clamped;
	logic                 walk_last;
	slew_req_t            slew_req;
	logic [DUTY_BITS-1:0] slew_next;

	logic                 tgt_we;
	logic [IDX_BITS-1:0]  tgt_idx;
	logic [DUTY_BITS-1:0] tgt_data;
	logic                 cur_we;
	logic                 load_out;
	logic                 load_kind;
	logic [CHAN_BITS-1:0] load_chan;
	logic [DUTY_BITS-1:0] load_duty;
	logic                 load_last;

	// Decode the addressed channel and clamp the set request
	always_comb begin
		chan_ok  = {1'b0, channel} < (CHAN_BITS+1)'(CHANNELS);
		chan_idx = IDX_BITS'(channel);
		if (MAG_BITS'(max_duty_q) > MAG_BITS'(DUTY_MAX)) begin
			limit = DUTY_BITS'(DUTY_MAX);
		end else begin
			limit = DUTY_BITS'(max_duty_q);
		end
		if (duty_request[REQ_BITS-1]) begin
			clamped = '0;
		end else if (duty_request > REQ_BITS'(limit)) begin
			clamped = limit;
		end else begin
			clamped = DUTY_BITS'(duty_request);
		end
	end

	// Feed the shared slew unit from the channel under walk
	assign walk_last = walk_idx_q == IDX_BITS'(CHANNELS - 1);
	assign slew_req  = '{clear: walk_stop_q, target: target_q[walk_idx_q],
		current: current_q[walk_idx_q], step: rate_step_q};

	mdsl_slew_unit u_slew (
		.req       (slew_req),
		.next_duty (slew_next)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// Sequencer: next state, store writes and output loads
	always_comb begin
		state_d     = state_q;
		walk_idx_d  = walk_idx_q;
		walk_stop_d = walk_stop_q;
		in_ready    = 1'b0;
		tgt_we      = 1'b0;
		tgt_idx     = walk_idx_q;
		tgt_data    = '0;
		cur_we      = 1'b0;
		load_out    = 1'b0;
		load_kind   = KIND_DRIVE;
		load_chan   = CHAN_BITS'(walk_idx_q);
		load_duty   = slew_next;
		load_last   = walk_last;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (in_fire) begin
					unique case (action_t'(action))
						ACT_SET: begin
							tgt_we   = chan_ok;
							tgt_idx  = chan_idx;
							tgt_data = clamped;
						end
						ACT_READ: begin
							load_out  = 1'b1;
							load_kind = KIND_READ;
							load_chan = channel;
							load_duty = chan_ok ? current_q[chan_idx] : '0;
							load_last = 1'b1;
						end
						ACT_TICK: begin
							state_d     = ST_WALK;
							walk_idx_d  = '0;
							walk_stop_d = 1'b0;
						end
						ACT_STOP: begin
							state_d     = ST_WALK;
							walk_idx_d  = '0;
							walk_stop_d = 1'b1;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (out_free) begin
					load_out = 1'b1;
					cur_we   = 1'b1;
					tgt_we   = walk_stop_q;
					if (walk_last) begin
						state_d = ST_IDLE;
					end else begin
						walk_idx_d = walk_idx_q + IDX_BITS'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_idx_q  <= '0;
			walk_stop_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			walk_idx_q  <= walk_idx_d;
			walk_stop_q <= walk_stop_d;
		end
	end

	// Hold the per-channel targets and currents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				target_q[i]  <= '0;
				current_q[i] <= '0;
			end
		end else begin
			if (tgt_we) begin
				target_q[tgt_idx] <= tgt_data;
			end
			if (cur_we) begin
				current_q[walk_idx_q] <= slew_next;
			end
		end
	end

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q  <= MAX_DUTY_RST;
			rate_step_q <= RATE_STEP_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_DUTY) begin
				max_duty_q <= cfg_data;
			end
			if (cfg_index == REG_RATE_STEP) begin
				rate_step_q <= cfg_data;
			end
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_kind_q <= load_kind;
			out_chan_q <= load_chan;
			out_duty_q <= load_duty;
			out_last_q <= load_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign result_channel = out_chan_q;
	assign result_duty    = RES_DUTY_BITS'(out_duty_q);
	assign last           = out_last_q;

	// A read reply always closes its request
	`ASSERT_CLK(a_read_last, (out_valid_q && out_kind_q == KIND_READ) |-> out_last_q, "read reply without last")

	// The closing drive update belongs to the highest channel
	`ASSERT_CLK(a_drive_last_chan, (out_valid_q && out_kind_q == KIND_DRIVE && out_last_q) |-> (out_chan_q == CHAN_BITS'(CHANNELS - 1)), "drive last on wrong channel")

	// A tick or stop starts its walk on channel zero
	`ASSERT_NEXT(a_walk_start, (in_fire && (action == ACT_TICK || action == ACT_STOP)), (state_q == ST_WALK && walk_idx_q == '0), "walk did not start at channel zero")

	// Stop drives only zero duty
	`ASSERT_CLK(a_stop_zero, (state_q == ST_WALK && walk_stop_q && load_out) |-> (load_duty == '0), "stop drove nonzero duty")

endmodule
